// ===== src/swmm_pkg.sv =====
`default_nettype none
package swmm_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int SAMPLE_W         = 32;
    localparam int COUNT_W          = 7;
    localparam int MEAN_W           = 36;
    localparam int FRAC_W           = 4;

    // sample moving down the chain
    typedef struct packed {
        logic                vld;
        logic [SAMPLE_W-1:0] data;
    } t_cell_data;

    // running extremes moving down the chain
    typedef struct packed {
        logic [SAMPLE_W-1:0] mn;
        logic [SAMPLE_W-1:0] mx;
    } t_wave;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage
`default_nettype wire

// ===== src/swmm_if.sv =====
`default_nettype none
interface swmm_in_if;
    import swmm_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_us;
    modport source (output valid, output sample_us, input ready);
    modport sink   (input valid, input sample_us, output ready);
endinterface

interface swmm_out_if;
    import swmm_pkg::*;
    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  window_count;
    logic [SAMPLE_W-1:0] window_min;
    logic [SAMPLE_W-1:0] window_max;
    logic [MEAN_W-1:0]   window_mean;
    modport source (output valid, output window_count, output window_min,
                    output window_max, output window_mean, input ready);
    modport sink   (input valid, input window_count, input window_min,
                    input window_max, input window_mean, output ready);
endinterface
`default_nettype wire

// ===== src/sliding_window_min_max_mean.sv =====
`default_nettype none
// Sliding-window statistics over duration samples.
// Input channel i_sample carries one 32-bit sample_us per word. Output channel
// o_result carries one word per sample: window_count, window_min, window_max
// and window_mean (sum*16/count, truncated, 32.4 fixed point).
// The window is a chain of WINDOW_DEPTH cells; a new sample enters the first
// cell and the oldest falls off the last. After the shift, running min/max
// ripple down the chain one cell per cycle, while a restoring divider makes
// one mean bit per cycle in parallel.
// The result is registered once the min/max scan has passed the last cell
// and the divider has finished, whichever is later. One sample is in work
// at a time, so a new sample is taken once the previous result has moved
// to the output register.
// The output register holds a result until taken; a next sample can be
// accepted meanwhile, but its result waits while the output is stalled.
// Reset (i_rst_n low, synchronous) empties the window, clears the sum and
// the pending result; no clearing pass is needed.
module sliding_window_min_max_mean
    import swmm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    swmm_in_if.sink    i_sample,
    swmm_out_if.source o_result
);

    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SW  = SAMPLE_W + CW;
    localparam int DW  = SW + FRAC_W;
    localparam int SCW = $clog2(WINDOW_DEPTH + 2);

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       n_cnt;
    logic [SW-1:0]       r_sum;
    logic [SW-1:0]       n_sum;
    logic [SCW-1:0]      r_scan;
    logic                r_out_vld;
    logic [COUNT_W-1:0]  r_out_cnt;
    logic [SAMPLE_W-1:0] r_out_min;
    logic [SAMPLE_W-1:0] r_out_max;
    logic [MEAN_W-1:0]   r_out_mean;
    logic                w_accept;
    logic                w_finish;
    logic                w_in_ready;
    logic                w_full;
    logic                w_div_busy;
    logic [DW-1:0]       w_quo;
    t_cell_data          w_dat [0:WINDOW_DEPTH];
    t_wave               w_wav [0:WINDOW_DEPTH];

    assign w_accept = i_sample.valid && w_in_ready;
    assign w_full   = r_cnt == CW'(WINDOW_DEPTH);

    assign w_dat[0] = '{vld: 1'b1, data: i_sample.sample_us};
    assign w_wav[0] = '{mn: '1, mx: '0};

    for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
        swmm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_dat   (w_dat[k]),
            .i_wav   (w_wav[k]),
            .o_dat   (w_dat[k+1]),
            .o_wav   (w_wav[k+1])
        );
    end

    // the last cell holds the oldest sample once the window is full
    always_comb begin
        n_sum = r_sum + SW'(i_sample.sample_us);
        n_cnt = r_cnt + 1'b1;
        if (w_full) begin
            n_sum = n_sum - SW'(w_dat[WINDOW_DEPTH].data);
            n_cnt = r_cnt;
        end
    end

    swmm_div #(.DW(DW), .CW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend ({n_sum, {FRAC_W{1'b0}}}),
        .i_divisor  (n_cnt),
        .o_busy     (w_div_busy),
        .o_quo      (w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_RUN;
            ST_RUN:  if (w_finish) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_finish   = 1'b0;
        unique case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_RUN:  w_finish = (r_scan == SCW'(WINDOW_DEPTH + 1)) && !w_div_busy &&
                                (!r_out_vld || o_result.ready);
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_scan    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt  <= n_cnt;
                r_sum  <= n_sum;
                r_scan <= '0;
            end else if (r_state == ST_RUN && r_scan != SCW'(WINDOW_DEPTH + 1)) begin
                r_scan <= r_scan + 1'b1;
            end
            if (w_finish) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_cnt  <= COUNT_W'(r_cnt);
            r_out_min  <= w_wav[WINDOW_DEPTH].mn;
            r_out_max  <= w_wav[WINDOW_DEPTH].mx;
            r_out_mean <= w_quo[MEAN_W-1:0];
        end
    end

    assign i_sample.ready        = w_in_ready;
    assign o_result.valid        = r_out_vld;
    assign o_result.window_count = r_out_cnt;
    assign o_result.window_min   = r_out_min;
    assign o_result.window_max   = r_out_max;
    assign o_result.window_mean  = r_out_mean;

endmodule
`default_nettype wire

// ===== src/swmm_cell.sv =====
`default_nettype none
module swmm_cell
    import swmm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_shift,
    input  wire t_cell_data i_dat,
    input  wire t_wave  i_wav,
    output t_cell_data  o_dat,
    output t_wave       o_wav
);

    logic                r_vld;
    logic [SAMPLE_W-1:0] r_data;
    t_wave               r_wav;
    t_wave               n_wav;

    always_comb begin
        n_wav = i_wav;
        if (r_vld) begin
            n_wav.mn = (r_data < i_wav.mn) ? r_data : i_wav.mn;
            n_wav.mx = (r_data > i_wav.mx) ? r_data : i_wav.mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_shift) begin
            r_vld <= i_dat.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_dat.data;
        end
        r_wav <= n_wav;
    end

    assign o_dat = '{vld: r_vld, data: r_data};
    assign o_wav = r_wav;

endmodule
`default_nettype wire

// ===== src/swmm_div.sv =====
`default_nettype none
module swmm_div
    import swmm_pkg::*;
#(
    parameter int DW = 42,
    parameter int CW = 7
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_start,
    input  wire  [DW-1:0] i_dividend,
    input  wire  [CW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quo
);

    localparam int NW = $clog2(DW + 1);

    logic [NW-1:0] r_cnt;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_div;
    logic [DW-1:0] r_quo;
    logic [CW:0]   w_sh;
    logic [CW:0]   w_diff;
    logic          w_ge;

    // restoring divide, one quotient bit per cycle
    assign w_sh   = {r_rem, r_quo[DW-1]};
    assign w_ge   = w_sh >= {1'b0, r_div};
    assign w_diff = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= NW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[CW-1:0] : w_sh[CW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

// ===== src/swmm_chk.sv =====
`default_nettype none
module swmm_chk
    import swmm_pkg::*;
(
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                i_in_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire [COUNT_W-1:0]  i_cnt,
    input wire [SAMPLE_W-1:0] i_min,
    input wire [SAMPLE_W-1:0] i_max,
    input wire [MEAN_W-1:0]   i_mean
);

    // one sample in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a sample is in work");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_min <= i_max)
        else $error("window min above max");

    // integer part of the mean lies between the extremes
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_mean[MEAN_W-1:FRAC_W] >= i_min) &&
                        (i_mean[MEAN_W-1:FRAC_W] <= i_max))
        else $error("mean outside window range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mean) &&
                                        $stable(i_min) && $stable(i_max) &&
                                        $stable(i_cnt))
        else $error("stalled result word changed");

endmodule

bind sliding_window_min_max_mean swmm_chk u_swmm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_cnt       (o_result.window_count),
    .i_min       (o_result.window_min),
    .i_max       (o_result.window_max),
    .i_mean      (o_result.window_mean)
);
`default_nettype wire

// ===== dv/sliding_window_min_max_mean_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module sliding_window_min_max_mean_tb;
    import swmm_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [SAMPLE_W-1:0] mn;
        logic [SAMPLE_W-1:0] mx;
        logic [MEAN_W-1:0]   mean;
    } t_stats;

    class window_scoreboard;
        logic [SAMPLE_W-1:0] ring [DEPTH];
        int unsigned         wr_ptr;
        int unsigned         fill;
        logic [37:0]         sum;
        t_stats              pending [$];
        int                  errors;

        function new();
            wr_ptr = 0;
            fill   = 0;
            sum    = '0;
            errors = 0;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            t_stats e;
            logic [41:0] scaled;
            if (fill >= DEPTH) sum = sum - ring[wr_ptr];
            else fill++;
            ring[wr_ptr] = s;
            sum = sum + s;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            e.mn = '1;
            e.mx = '0;
            for (int i = 0; i < fill; i++) begin
                if (ring[i] < e.mn) e.mn = ring[i];
                if (ring[i] > e.mx) e.mx = ring[i];
            end
            scaled = {sum, 4'b0};
            e.mean = MEAN_W'(scaled / fill);
            e.count = COUNT_W'(fill);
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(t_stats got);
            t_stats e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (got.count !== e.count) begin
                $display("%0t: count exp %0d got %0d", $time, e.count, got.count);
                errors++;
            end
            if (got.mn !== e.mn) begin
                $display("%0t: min exp %h got %h", $time, e.mn, got.mn);
                errors++;
            end
            if (got.mx !== e.mx) begin
                $display("%0t: max exp %h got %h", $time, e.mx, got.mx);
                errors++;
            end
            if (got.mean !== e.mean) begin
                $display("%0t: mean exp %h got %h", $time, e.mean, got.mean);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    swmm_in_if  sample_ch ();
    swmm_out_if result_ch ();

    sliding_window_min_max_mean dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_result (result_ch.source)
    );

    window_scoreboard sb;
    bit  quiet;
    bit  timed_out;
    int  cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.sample_us = '0;
        result_ch.ready = 1'b0;
    end

    // sample words and results on the edge, before the nonblocking updates land
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (sample_ch.valid && sample_ch.ready) sb.note_sample(sample_ch.sample_us);
            if (result_ch.valid && result_ch.ready)
                sb.check_result({result_ch.window_count, result_ch.window_min,
                                 result_ch.window_max, result_ch.window_mean});
        end
    end
    initial cycles = 0;

    // receiver stalls in bursts
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                result_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_word(logic [SAMPLE_W-1:0] s);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            sample_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample_us <= s;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(0, 1000));
            3: return 32'hFFFF_FF00 | SAMPLE_W'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        quiet = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes during the first fill
        send_word('0);
        send_word('1);
        send_word(32'h8000_0000);
        send_word(32'h0000_0001);
        send_word(32'h7FFF_FFFF);
        send_word(32'hAAAA_AAAA);
        send_word(32'h5555_5555);
        sample_ch.valid <= 1'b0;
        drain();
        // a run of max values, then random words that fill and wrap the window
        for (int i = 0; i < 18; i++) send_word('1);
        for (int i = 0; i < 600; i++) begin
            if (i == 300) begin
                sample_ch.valid <= 1'b0;
                drain();
            end
            if (i == 520) quiet = 1'b1;
            send_word(rand_sample());
        end
        sample_ch.valid <= 1'b0;
        drain();
        repeat (80) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("sliding_window_min_max_mean_tb: done, clean");
        end else begin
            $display("sliding_window_min_max_mean_tb: done, errors");
        end
        $finish;
    end

    initial begin
        wait (cycles >= LIMIT_CYCLES);
        $display("sliding_window_min_max_mean_tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/swmm_pkg.sv
src/swmm_if.sv
src/swmm_cell.sv
src/swmm_div.sv
src/sliding_window_min_max_mean.sv
src/swmm_chk.sv
dv/sliding_window_min_max_mean_tb.sv
